// ===== rtl/core/tagf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagf_pkg
// Shared widths, limits and types of the time-aligned group filter.
// ----------------------------------------------------------------------------
package tagf_pkg;

    localparam int EVENT_W         = 16;
    localparam int HW_W            = 3;
    localparam int MAX_HALF_WINDOW = 7;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW        = $clog2(QUEUE_DEPTH + 1);

    // One completed group: emit first..last, all tagged with the half window.
    typedef struct packed {
        logic [EVENT_W-1:0] first;
        logic [EVENT_W-1:0] last;
        logic [HW_W-1:0]    hw;
    } t_job;

    // Queue status seen by the back end.
    typedef struct packed {
        logic valid;
        t_job head;
    } t_queue_head;

endpackage
`default_nettype wire

// ===== rtl/core/tagf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagf_front
// Tracks group state per event and turns each completed group into a job.
// ----------------------------------------------------------------------------
module tagf_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_wr_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [tagf_pkg::EVENT_W-1:0] i_event_number,
    input  wire                          i_in_group,
    input  wire                          i_group_first,
    input  wire                          i_group_central,
    input  wire                          i_batch_last,
    input  wire                          i_queue_full,
    output logic                         o_push,
    output tagf_pkg::t_job               o_job
);
    import tagf_pkg::*;

    logic               r_emit_sub;
    logic               r_inside,  n_inside;
    logic [EVENT_W-1:0] r_start,   n_start;
    logic [EVENT_W-1:0] r_window,  n_window;
    logic               r_cseen,   n_cseen;
    logic [EVENT_W-1:0] r_prev,    n_prev;

    logic               accept;
    logic               no_gap;
    logic               end_match;
    logic               narrow;
    logic               emit;
    logic [EVENT_W:0]   prev_inc;
    logic [EVENT_W+1:0] end_sum;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    assign prev_inc  = {1'b0, r_prev} + {{EVENT_W{1'b0}}, 1'b1};
    assign no_gap    = (i_event_number == r_prev) || ({1'b0, i_event_number} == prev_inc);
    // start + 2*window, kept wide so an overflow never matches
    assign end_sum   = {2'b00, r_start} + {1'b0, r_window, 1'b0};
    assign end_match = end_sum == {2'b00, i_event_number};
    assign narrow    = r_window <= EVENT_W'(MAX_HALF_WINDOW);

    always_comb begin
        n_inside = r_inside;
        n_start  = r_start;
        n_window = r_window;
        n_cseen  = r_cseen;
        n_prev   = r_prev;
        emit     = 1'b0;
        priority if (!r_inside) begin
            if (i_group_first && i_in_group) begin
                n_inside = 1'b1;
                n_start  = i_event_number;
                n_window = '0;
                n_cseen  = 1'b0;
                n_prev   = i_event_number;
            end
        end else if (!i_in_group) begin
            n_inside = 1'b0;
        end else if (i_group_first) begin
            n_start  = i_event_number;
            n_window = '0;
            n_cseen  = 1'b0;
            n_prev   = i_event_number;
        end else if (!no_gap) begin
            n_inside = 1'b0;
        end else begin
            if (i_group_central) begin
                n_window = i_event_number - r_start;
                n_cseen  = 1'b1;
            end else if (r_cseen && end_match && narrow) begin
                emit = 1'b1;
            end
            n_prev = i_event_number;
        end
        if (i_batch_last) begin
            n_inside = 1'b0;
            n_start  = '0;
            n_window = '0;
            n_cseen  = 1'b0;
            n_prev   = '0;
        end
    end

    assign o_push     = accept && emit;
    assign o_job.hw   = r_window[HW_W-1:0];
    assign o_job.first = r_emit_sub ? r_start : (r_start + r_window);
    assign o_job.last  = r_emit_sub ? i_event_number : (r_start + r_window);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_sub <= 1'b0;
            r_inside   <= 1'b0;
            r_start    <= '0;
            r_window   <= '0;
            r_cseen    <= 1'b0;
            r_prev     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_emit_sub <= i_cfg_wr_data;
            end
            if (accept) begin
                r_inside <= n_inside;
                r_start  <= n_start;
                r_window <= n_window;
                r_cseen  <= n_cseen;
                r_prev   <= n_prev;
            end
        end
    end

`ifndef ASSERT_OFF
    a_batch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_batch_last) |=> (!r_inside && !r_cseen && r_window == '0))
        else $error("group state not cleared after batch end");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tagf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagf_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
module tagf_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tagf_pkg::t_job       i_job,
    input  wire                  i_pop,
    output logic                 o_full,
    output tagf_pkg::t_queue_head o_head
);
    import tagf_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr;
    logic [QUEUE_AW-1:0] r_rptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_CW-1:0] n_count;

    assign o_full      = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.head  = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QUEUE_CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QUEUE_AW'(1);
            end
            r_count <= n_count;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into full job queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty job queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/tagf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagf_back
// Expands each job into its run of results through the output register.
// ----------------------------------------------------------------------------
module tagf_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  tagf_pkg::t_queue_head        i_head,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [tagf_pkg::EVENT_W-1:0] o_selected_event,
    output logic [tagf_pkg::HW_W-1:0]    o_half_window,
    output logic                         o_run_end
);
    import tagf_pkg::*;

    logic               r_valid;
    logic [EVENT_W-1:0] r_sel;
    logic [EVENT_W-1:0] r_last;
    logic [HW_W-1:0]    r_hw;
    logic               r_end;

    logic               slot_free;
    logic               advance;
    logic [EVENT_W-1:0] sel_inc;

    assign slot_free = !r_valid || i_out_ready;
    assign advance   = slot_free && r_valid && !r_end;
    assign o_pop     = slot_free && !(r_valid && !r_end) && i_head.valid;
    assign sel_inc   = r_sel + EVENT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (slot_free) begin
            r_valid <= advance || i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sel <= sel_inc;
            r_end <= sel_inc == r_last;
        end else if (o_pop) begin
            r_sel  <= i_head.head.first;
            r_last <= i_head.head.last;
            r_hw   <= i_head.head.hw;
            r_end  <= i_head.head.first == i_head.head.last;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_selected_event = r_sel;
    assign o_half_window    = r_hw;
    assign o_run_end        = r_end;

`ifndef ASSERT_OFF
    a_run_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_end ? (r_sel == r_last) : (r_sel < r_last)))
        else $error("result run passed its last event");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/time_aligned_group_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// time_aligned_group_filter
// Filters an event stream down to completed time-aligned groups.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  events    in         i_in_valid / o_in_ready       event number, group flags, batch end
//  results   out        o_out_valid / i_out_ready     selected event, half window, run end
//  config    in         i_cfg_wr_en (no wait)         emit_sub_events
//
//  An event is taken whenever the job queue (2 entries) has room.
//  A completed group yields one job; the back end sends one result per cycle while
//  the output is ready: 2*half_window+1 results in sub-event mode, one otherwise.
//  Synchronous active-low reset clears group state, queue, output and config.
//  Output stalls fill the queue, after which event requests wait.
// ----------------------------------------------------------------------------
module time_aligned_group_filter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire                          i_cfg_wr_data,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [tagf_pkg::EVENT_W-1:0] i_event_number,
    input  wire                          i_in_group,
    input  wire                          i_group_first,
    input  wire                          i_group_central,
    input  wire                          i_batch_last,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [tagf_pkg::EVENT_W-1:0] o_selected_event,
    output logic [tagf_pkg::HW_W-1:0]    o_half_window,
    output logic                         o_run_end
);
    import tagf_pkg::*;

    logic        push;
    logic        pop;
    logic        queue_full;
    t_job        job;
    t_queue_head head;

    tagf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_event_number  (i_event_number),
        .i_in_group      (i_in_group),
        .i_group_first   (i_group_first),
        .i_group_central (i_group_central),
        .i_batch_last    (i_batch_last),
        .i_queue_full    (queue_full),
        .o_push          (push),
        .o_job           (job)
    );

    tagf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    tagf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_selected_event (o_selected_event),
        .o_half_window    (o_half_window),
        .o_run_end        (o_run_end)
    );

endmodule
`default_nettype wire
